// ===== hw/rtl/grr_pkg.sv =====
// shared types and constants for the lagged-xor random generator
package grr_pkg;

  localparam int unsigned TABLE_LEN  = 521;
  localparam int unsigned ADDR_W     = $clog2(TABLE_LEN);
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LAG        = 32;
  localparam int unsigned SEED_WORDS = 17;
  localparam int unsigned BIT_CNT_W  = $clog2(WORD_W);
  localparam int unsigned SHL_AMT    = 23;
  localparam int unsigned SHR_AMT    = 9;

  localparam logic [WORD_W-1:0]    LCG_MUL  = 32'h5d58_8b65;
  localparam logic [ADDR_W-1:0]    LAST_POS = ADDR_W'(TABLE_LEN - 1);
  localparam logic [ADDR_W-1:0]    FIX_IDX  = ADDR_W'(SEED_WORDS - 1);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W - 1);

  // request codes
  localparam logic REQ_RAW    = 1'b0;
  localparam logic REQ_RANGED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HARVEST,
    ST_FIX16,
    ST_FILL,
    ST_WARM_RD,
    ST_WARM_WR,
    ST_DISPATCH,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_DIV,
    ST_OUT
  } grr_state_e;

  // handshake between sequencer and modulo unit
  typedef struct packed {
    logic done;
    logic busy;
  } grr_div_status_t;

endpackage

// ===== hw/rtl/grr_ram.sv =====
// generic single-write, single-read ram with registered read data
module grr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/grr_div.sv =====
// iterative 32-bit unsigned remainder unit, one quotient bit per cycle
module grr_div import grr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_W-1:0]     dividend_i,
  input  logic [WORD_W-1:0]     divisor_i,
  output grr_div_status_t       status_o,
  output logic [WORD_W-1:0]     rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W:0]      rem_q, rem_d;
  logic [WORD_W-1:0]    dvd_q, dvd_d;
  logic [WORD_W-1:0]    dsr_q, dsr_d;
  logic [WORD_W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    trial  = {rem_q[WORD_W-1:0], dvd_q[WORD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // restoring step: subtract when the partial remainder allows it
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
      end else begin
        rem_d = trial;
      end
      dvd_d = {dvd_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_BIT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign status_o.done = done_q;
  assign status_o.busy = busy_q;
  assign rem_o         = rem_q[WORD_W-1:0];

endmodule

// ===== hw/rtl/gfsr_random_ranged_top.sv =====
// top level of the lagged-xor random word generator with ranged draw
//
// channels: one request per input transfer (req_type, range_low, range_high),
// one draw_value per output transfer, and a seed write channel
// - every request gives exactly one result, in order
// - a raw draw passes dispatch, a ring read and a ring write before out_valid_o;
//   a ranged draw with a nonzero span also waits for the serial remainder unit;
//   equal bounds return range_low without stepping the ring
// - one request is worked on at a time; in_ready_o rises again once the
//   result sits in the output register, so the next request can be taken
//   while that result still waits for out_ready_i
// - the first request after reset or after a seed write first builds the
//   521-word table: lcg harvest of 17 seed words, fill of the rest and two
//   warm-up passes over the ring, all ahead of the draw itself
// - reset clears the seed to zero, marks the table unbuilt and sets the ring
//   position to its last entry; table contents stay undefined until built
// - a stalled receiver holds draw_value_o stable; no result is ever dropped
// - seed writes are taken only while the sequencer is idle
module gfsr_random_ranged_top import grr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] draw_value_o,
  // seed write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        seed_value_i
);

  grr_state_e state_q, state_d;

  // control registers
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic                 pass_q, pass_d;
  logic                 built_q, built_d;
  logic [WORD_W-1:0]    seed_q, seed_d;
  logic                 out_valid_q, out_valid_d;

  // payload registers
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic              req_q, req_d;
  logic [WORD_W-1:0] lo_q, lo_d;
  logic [WORD_W-1:0] hi_q, hi_d;
  logic [WORD_W-1:0] span_q, span_d;
  logic [WORD_W-1:0] res_q, res_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;

  // last LAG words written to the ring, entry 0 the newest
  logic [WORD_W-1:0] lag_q [LAG];
  logic [WORD_W-1:0] lag_d [LAG];
  logic              lag_shift;
  logic              lag_load0;
  logic [WORD_W-1:0] lag_word;

  // table memory
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // remainder unit
  logic              div_start;
  grr_div_status_t   div_status;
  logic [WORD_W-1:0] div_rem;

  // shared datapath terms
  logic [WORD_W-1:0] lcg_next;
  logic [WORD_W-1:0] acc_next;
  logic [ADDR_W-1:0] pos_next;
  logic [WORD_W-1:0] ring_word;
  logic              in_xfer;
  logic              cfg_xfer;
  logic              out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // lcg step and top-bit harvest
  assign lcg_next  = x_q * LCG_MUL + 32'd1;
  assign acc_next  = {lcg_next[WORD_W-1], acc_q[WORD_W-1:1]};
  assign pos_next  = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
  // ring update: current entry xor the entry LAG places back
  assign ring_word = ram_rdata ^ lag_q[LAG-1];

  grr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_LEN)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the remainder unit latches the fresh ring word at start
  grr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ring_word),
    .divisor_i  (span_q),
    .status_o   (div_status),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = built_q ? ST_DISPATCH : ST_HARVEST;
        end
      end
      ST_HARVEST: begin
        if (bit_cnt_q == LAST_BIT && idx_q == FIX_IDX) begin
          state_d = ST_FIX16;
        end
      end
      ST_FIX16: state_d = ST_FILL;
      ST_FILL: begin
        if (idx_q == LAST_POS) begin
          state_d = ST_WARM_RD;
        end
      end
      ST_WARM_RD: state_d = ST_WARM_WR;
      ST_WARM_WR: begin
        if (pos_q == LAST_POS && pass_q) begin
          state_d = ST_DISPATCH;
        end else begin
          state_d = ST_WARM_RD;
        end
      end
      ST_DISPATCH: begin
        if (req_q == REQ_RANGED && lo_q == hi_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DRAW_RD;
        end
      end
      ST_DRAW_RD: state_d = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (req_q == REQ_RANGED && span_q != '0) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    bit_cnt_d   = bit_cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pass_d      = pass_q;
    built_d     = built_q;
    seed_d      = seed_q;
    x_d         = x_q;
    acc_d       = acc_q;
    req_d       = req_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    span_d      = span_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    ram_raddr   = pos_q;
    div_start   = 1'b0;
    lag_shift   = 1'b0;
    lag_load0   = 1'b0;
    lag_word    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_xfer) begin
          seed_d  = seed_value_i;
          built_d = 1'b0;
        end
        if (in_xfer) begin
          req_d     = req_type_i;
          lo_d      = range_low_i;
          hi_d      = range_high_i;
          x_d       = seed_q;
          acc_d     = '0;
          bit_cnt_d = '0;
          idx_d     = '0;
        end
      end
      ST_HARVEST: begin
        x_d       = lcg_next;
        acc_d     = acc_next;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == LAST_BIT) begin
          ram_we    = 1'b1;
          ram_wdata = acc_next;
          lag_shift = 1'b1;
          lag_word  = acc_next;
          idx_d     = idx_q + 1'b1;
        end
      end
      ST_FIX16: begin
        // rework the last seed word from words 0, 15 and 16
        lag_word  = (lag_q[0] << SHL_AMT) ^ (lag_q[SEED_WORDS-1] >> SHR_AMT) ^ lag_q[1];
        lag_load0 = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = FIX_IDX;
        ram_wdata = lag_word;
      end
      ST_FILL: begin
        lag_word  = (lag_q[SEED_WORDS-1] << SHL_AMT) ^ (lag_q[SEED_WORDS-2] >> SHR_AMT)
                    ^ lag_q[0];
        lag_shift = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = lag_word;
        idx_d     = idx_q + 1'b1;
        if (idx_q == LAST_POS) begin
          pos_d  = LAST_POS;
          pass_d = 1'b0;
        end
      end
      ST_WARM_RD, ST_DRAW_RD: begin
        pos_d     = pos_next;
        ram_raddr = pos_next;
      end
      ST_WARM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = ring_word;
        lag_shift = 1'b1;
        lag_word  = ring_word;
        if (pos_q == LAST_POS) begin
          if (pass_q) begin
            built_d = 1'b1;
          end else begin
            pass_d = 1'b1;
          end
        end
      end
      ST_DISPATCH: begin
        span_d = hi_q - lo_q + 32'd1;
        if (req_q == REQ_RANGED && lo_q == hi_q) begin
          res_d = lo_q;
        end
      end
      ST_DRAW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = ring_word;
        lag_shift = 1'b1;
        lag_word  = ring_word;
        res_d     = ring_word;
        if (req_q == REQ_RANGED && span_q != '0) begin
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          res_d = lo_q + div_rem;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    for (int k = 0; k < LAG; k++) begin
      lag_d[k] = lag_q[k];
    end
    if (lag_shift) begin
      lag_d[0] = lag_word;
      for (int k = 1; k < LAG; k++) begin
        lag_d[k] = lag_q[k-1];
      end
    end else if (lag_load0) begin
      lag_d[0] = lag_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      idx_q       <= '0;
      pos_q       <= LAST_POS;
      pass_q      <= 1'b0;
      built_q     <= 1'b0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      pass_q      <= pass_d;
      built_q     <= built_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    acc_q      <= acc_d;
    req_q      <= req_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    span_q     <= span_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
    lag_q      <= lag_d;
  end

  assign out_valid_o  = out_valid_q;
  assign draw_value_o = out_data_q;

endmodule

// ===== hw/rtl/grr_checker.sv =====
// port-level checks for the random generator top, bound to it below
module grr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] draw_value_o,
  input logic               cfg_ready_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // requests taken whose result has not yet been handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // a result never shows up without a request behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 2'd0))
    else $error("result without outstanding request");

  // at most one request in work plus one result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many outstanding requests");

  // one request at a time: ready drops right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("request taken while previous one still in work");

  // seed writes are taken only while requests are also taken, i.e. while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> in_ready_o)
    else $error("seed port open while sequencer busy");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(draw_value_o)))
    else $error("stalled result changed");

endmodule

bind gfsr_random_ranged_top grr_checker u_grr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .draw_value_o (draw_value_o),
  .cfg_ready_o  (cfg_ready_o)
);
